/* rtl/ptgs_pkg.sv */
// ----------------------------------------------------------------------------
// ptgs_pkg
// Shared widths, codes and defaults of the prefix threshold galloping search.
// ----------------------------------------------------------------------------
package ptgs_pkg;

  // Default storage shape
  localparam int DEFAULT_TABLE_DEPTH = 4096;
  localparam int DEFAULT_SUM_WIDTH   = 32;

  // Fixed field widths
  localparam int FUNC_W   = 1;
  localparam int INDEX_W  = 12;
  localparam int VALUE_W  = 32;
  localparam int LENGTH_W = 13;
  localparam int LAST_W   = 13;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

  // Result when no position qualifies
  localparam logic signed [LAST_W-1:0] LAST_NONE = -13'sd1;

endpackage

/* rtl/ptgs_table.sv */
// ----------------------------------------------------------------------------
// ptgs_table
// Prefix-sum table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptgs_table
  import ptgs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int SUM_WIDTH   = DEFAULT_SUM_WIDTH,
  localparam int AW         = $clog2(TABLE_DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [SUM_WIDTH-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [SUM_WIDTH-1:0] rd_data
);

  logic [SUM_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [SUM_WIDTH-1:0] rd_data_r;

  // Store one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry, data valid next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/prefix_threshold_galloping_search_unit.sv */
// A query issues one table probe per cycle through its galloping and bisection
//   steps; a write request is stored from the idle state without leaving it.
// Requests are taken one at a time: in_stall is high whenever the unit is not idle.
// A query starting at or beyond the table length returns LAST_NONE unsearched.
// Reset clears control state and the table length; table contents stay
//   undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
// prefix_threshold_galloping_search_unit
// Stores prefix log-probability sums and answers threshold queries by a
// galloping search followed by bisection over the stored table.
// ----------------------------------------------------------------------------
module prefix_threshold_galloping_search_unit
  import ptgs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int SUM_WIDTH   = DEFAULT_SUM_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [FUNC_W-1:0]          in_func,
  input  logic [INDEX_W-1:0]         in_entry_index,
  input  logic signed [VALUE_W-1:0]  in_entry_value,
  input  logic [INDEX_W-1:0]         in_start_position,
  input  logic signed [VALUE_W-1:0]  in_threshold,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [LAST_W-1:0]   out_last_index,
  // Configuration channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [LENGTH_W-1:0]        cfg_table_length
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = (AW + 3 > 15) ? AW + 3 : 15;
  localparam int DW = (SUM_WIDTH + 1 > 32) ? SUM_WIDTH + 1 : 32;

  typedef logic signed [CW-1:0] idx_t;
  typedef logic signed [DW-1:0] sum_t;

  localparam idx_t IDX_ONE = idx_t'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BEFORE,
    S_GALLOP,
    S_BISECT,
    S_RESULT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [LENGTH_W-1:0]       table_length_r, table_length_nxt;
  idx_t                      s_r, s_nxt;
  idx_t                      beg_r, beg_nxt;
  idx_t                      end_r, end_nxt;
  idx_t                      win_r, win_nxt;
  idx_t                      probe_r, probe_nxt;
  sum_t                      before_r, before_nxt;
  sum_t                      thr_r, thr_nxt;
  logic signed [LAST_W-1:0]  res_r, res_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [LAST_W-1:0]  out_last_r, out_last_nxt;

  logic [CW-1:0]             depth_c;
  logic [CW-1:0]             len_ext;
  idx_t                      n_s;
  idx_t                      s_in;
  logic [CW-1:0]             wr_idx_ext;
  sum_t                      wr_ext;
  logic                      wr_en;
  logic                      rd_en;
  idx_t                      rd_idx;
  logic [SUM_WIDTH-1:0]      rd_data;
  sum_t                      rd_val;
  logic                      qual;
  idx_t                      gal_np;
  idx_t                      b2;
  idx_t                      e2;
  idx_t                      mid_c;
  logic                      narrow_go;

  // Effective table length, clamped to the storage depth
  assign depth_c = CW'(TABLE_DEPTH);
  assign len_ext = CW'(table_length_r);
  assign n_s     = $signed((len_ext > depth_c) ? depth_c : len_ext);

  // Request field views
  assign s_in       = $signed(CW'(in_start_position));
  assign wr_idx_ext = CW'(in_entry_index);
  assign wr_ext     = DW'(in_entry_value);

  // Probe test: entry minus the sum before the start meets the threshold
  assign rd_val = DW'($signed(rd_data));
  assign qual   = (rd_val - before_r) >= thr_r;

  // Next galloping probe and the narrowed bisection interval
  assign gal_np    = probe_r + (win_r <<< 1);
  assign b2        = qual ? probe_r : beg_r;
  assign e2        = qual ? ((state_r == S_GALLOP) ? n_s : end_r) : probe_r;
  assign mid_c     = (b2 + e2) >>> 1;
  assign narrow_go = b2 < (e2 - IDX_ONE);

  // Handshake outputs
  assign in_stall       = (state_r != S_IDLE);
  assign cfg_ready      = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_last_index = out_last_r;

  // Sequence writes, probes and result hand-off
  always_comb begin
    state_nxt        = state_r;
    table_length_nxt = table_length_r;
    s_nxt            = s_r;
    beg_nxt          = beg_r;
    end_nxt          = end_r;
    win_nxt          = win_r;
    probe_nxt        = probe_r;
    before_nxt       = before_r;
    thr_nxt          = thr_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_last_nxt     = out_last_r;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    rd_idx           = probe_r;

    if (cfg_valid && cfg_ready) begin
      table_length_nxt = cfg_table_length;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_WRITE) begin
            // Drop writes beyond the storage depth
            wr_en = (wr_idx_ext < depth_c);
          end else begin
            s_nxt   = s_in;
            thr_nxt = DW'(in_threshold);
            if (s_in >= n_s) begin
              res_nxt   = LAST_NONE;
              state_nxt = S_RESULT;
            end else if (s_in == '0) begin
              before_nxt = '0;
              beg_nxt    = -IDX_ONE;
              win_nxt    = IDX_ONE;
              probe_nxt  = s_in;
              rd_en      = 1'b1;
              rd_idx     = s_in;
              state_nxt  = S_GALLOP;
            end else begin
              beg_nxt   = s_in - IDX_ONE;
              win_nxt   = IDX_ONE;
              probe_nxt = s_in;
              rd_en     = 1'b1;
              rd_idx    = s_in - IDX_ONE;
              state_nxt = S_BEFORE;
            end
          end
        end
      end

      S_BEFORE: begin
        // Capture the sum before the start, probe the start itself
        before_nxt = rd_val;
        rd_en      = 1'b1;
        rd_idx     = probe_r;
        state_nxt  = S_GALLOP;
      end

      S_GALLOP, S_BISECT: begin
        if (state_r == S_GALLOP && qual && gal_np < n_s) begin
          // Advance and double the step
          beg_nxt   = probe_r;
          win_nxt   = win_r <<< 1;
          probe_nxt = gal_np;
          rd_en     = 1'b1;
          rd_idx    = gal_np;
        end else if (narrow_go) begin
          // Bisect the remaining interval
          beg_nxt   = b2;
          end_nxt   = e2;
          probe_nxt = mid_c;
          rd_en     = 1'b1;
          rd_idx    = mid_c;
          state_nxt = S_BISECT;
        end else begin
          res_nxt   = (b2 < s_r) ? LAST_NONE : LAST_W'(b2);
          state_nxt = S_RESULT;
        end
      end

      S_RESULT: begin
        // Hold until the output register frees up
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      table_length_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      table_length_r <= table_length_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    s_r        <= s_nxt;
    beg_r      <= beg_nxt;
    end_r      <= end_nxt;
    win_r      <= win_nxt;
    probe_r    <= probe_nxt;
    before_r   <= before_nxt;
    thr_r      <= thr_nxt;
    res_r      <= res_nxt;
    out_last_r <= out_last_nxt;
  end

  ptgs_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SUM_WIDTH   (SUM_WIDTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx_ext[AW-1:0]),
    .wr_data (wr_ext[SUM_WIDTH-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

`ifndef SYNTH
  // Every probe stays inside the valid part of the table
  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GALLOP || state_r == S_BISECT) |-> (probe_r >= '0 && probe_r < n_s))
    else $error("probe outside table");

  // Bisection probes lie strictly inside the open interval
  a_bisect_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BISECT) |-> (beg_r < probe_r && probe_r < end_r))
    else $error("bisection probe outside interval");

  // The lower bound never falls below the entry before the start
  a_beg_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GALLOP || state_r == S_BISECT) |-> (beg_r >= s_r - IDX_ONE))
    else $error("search bound below start");

  // A finished result waits while the output register is held
  a_result_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && out_valid_r && out_stall) |=> (state_r == S_RESULT))
    else $error("result dropped while output held");

  // A new result only comes from the result state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_RESULT))
    else $error("result without finished query");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives write and query requests into the prefix threshold galloping search
// unit with random idle and stall, models the table search in step with the
// accepted requests, and checks every returned last index in order.
// ----------------------------------------------------------------------------
module testbench;
  import ptgs_pkg::*;

  localparam int DEPTH         = DEFAULT_TABLE_DEPTH;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int CALM_FIRST    = 3000;
  localparam int CALM_LAST     = 9000;
  localparam int IDLE_PERCENT  = 12;
  localparam int ITEM_TARGET   = 1100;
  localparam int HOLD_AT       = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int REPORT_LIMIT  = 10;
  localparam int RING_DEPTH    = 16;
  localparam int ROW_LIMIT     = 32;

  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  typedef enum logic {ROW_CONFIG, ROW_REQUEST} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [LENGTH_W-1:0]       length;
    logic [FUNC_W-1:0]         func;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        start;
    logic signed [VALUE_W-1:0] thr;
    bit                        typed;
    logic signed [LAST_W-1:0]  last;
  } vector_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [FUNC_W-1:0]          in_func = FUNC_WRITE;
  logic [INDEX_W-1:0]         in_entry_index = '0;
  logic signed [VALUE_W-1:0]  in_entry_value = '0;
  logic [INDEX_W-1:0]         in_start_position = '0;
  logic signed [VALUE_W-1:0]  in_threshold = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [LAST_W-1:0]   out_last_index;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [LENGTH_W-1:0]        cfg_table_length = '0;

  // Mirror of the table and the length register
  logic signed [VALUE_W-1:0]  prefix_sums [DEPTH];
  logic [LENGTH_W-1:0]        length_reg = '0;

  // Expected results in request order
  logic signed [LAST_W-1:0]   want_ring [RING_DEPTH];
  int unsigned                ring_wr = 0;
  int unsigned                ring_rd = 0;

  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  vector_t     directed_rows [ROW_LIMIT];
  int          row_count = 0;

  prefix_threshold_galloping_search_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_entry_index   (in_entry_index),
    .in_entry_value   (in_entry_value),
    .in_start_position(in_start_position),
    .in_threshold     (in_threshold),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_last_index   (out_last_index),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_table_length (cfg_table_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Idle on roughly 12 percent of calls, except through the calm window
  function automatic bit roll_idle();
    if (cycle_count >= CALM_FIRST && cycle_count < CALM_LAST) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PERCENT;
  endfunction

  function automatic logic signed [VALUE_W-1:0] clamp_sum(input longint v);
    if (v > SUM_MAX) return SUM_MAX[VALUE_W-1:0];
    if (v < SUM_MIN) return SUM_MIN[VALUE_W-1:0];
    return v[VALUE_W-1:0];
  endfunction

  // Factor sum test, taken exactly in 64 bits
  function automatic bit meets(input longint x, input longint base,
                               input logic signed [VALUE_W-1:0] thr);
    return longint'(prefix_sums[x]) - base >= longint'(thr);
  endfunction

  // Gallop by doubling steps, then bisect down to the last qualifying position
  function automatic logic signed [LAST_W-1:0] search_last(
    input logic [INDEX_W-1:0] start, input logic signed [VALUE_W-1:0] thr);
    longint n, s, base, beg, stop, win, mid;
    n = (length_reg > DEPTH) ? longint'(DEPTH) : longint'(length_reg);
    s = longint'(start);
    if (s >= n) return LAST_NONE;
    base = (s == 0) ? 0 : longint'(prefix_sums[s-1]);
    beg = s - 1;
    win = 1;
    while (beg + win < n && meets(beg + win, base, thr)) begin
      beg += win;
      win *= 2;
    end
    stop = (beg + win >= n) ? n : beg + win;
    while (beg < stop - 1) begin
      mid = (beg + stop) / 2;
      if (meets(mid, base, thr)) beg = mid;
      else stop = mid;
    end
    return (beg < s) ? LAST_NONE : LAST_W'(beg);
  endfunction

  function automatic vector_t blank_row();
    vector_t r;
    r.kind   = ROW_REQUEST;
    r.length = '0;
    r.func   = FUNC_WRITE;
    r.index  = '0;
    r.value  = '0;
    r.start  = '0;
    r.thr    = '0;
    r.typed  = 1'b0;
    r.last   = LAST_NONE;
    return r;
  endfunction

  function automatic vector_t length_row(input int unsigned len);
    vector_t r;
    r = blank_row();
    r.kind = ROW_CONFIG;
    r.length = LENGTH_W'(len);
    return r;
  endfunction

  function automatic vector_t write_row(input int unsigned idx,
                                        input logic signed [VALUE_W-1:0] val);
    vector_t r;
    r = blank_row();
    r.kind = ROW_REQUEST;
    r.func = FUNC_WRITE;
    r.index = INDEX_W'(idx);
    r.value = val;
    return r;
  endfunction

  function automatic vector_t query_row(input int unsigned s,
                                        input logic signed [VALUE_W-1:0] thr,
                                        input bit typed,
                                        input logic signed [LAST_W-1:0] last);
    vector_t r;
    r = blank_row();
    r.kind = ROW_REQUEST;
    r.func = FUNC_QUERY;
    r.start = INDEX_W'(s);
    r.thr = thr;
    r.typed = typed;
    r.last = last;
    return r;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input vector_t r);
    directed_rows[row_count] = r;
    row_count++;
  endfunction

  function automatic void report(input string what,
                                 input logic signed [LAST_W-1:0] want,
                                 input logic signed [LAST_W-1:0] got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("%s: last_index expected %0d, got %0d", what, want, got);
  endfunction

  // Offer one request, hold it until accepted, then advance the mirror
  task automatic push_request(input vector_t r);
    while (roll_idle()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= r.func;
    in_entry_index    <= r.index;
    in_entry_value    <= r.value;
    in_start_position <= r.start;
    in_threshold      <= r.thr;
    do @(posedge clk); while (in_stall !== 1'b0);
    requests_sent++;
    if (r.func == FUNC_WRITE) begin
      prefix_sums[r.index] = r.value;
    end else begin
      want_ring[ring_wr % RING_DEPTH] = r.typed ? r.last : search_last(r.start, r.thr);
      ring_wr++;
    end
  endtask

  // Drain all results and let trailing writes settle before a length change
  task automatic apply_length(input logic [LENGTH_W-1:0] len);
    if (in_valid) in_valid <= 1'b0;
    while (ring_wr != ring_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_table_length <= len;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    length_reg = len;
  endtask

  // One random phase: set a length, fill a written window, then query, mostly inside it
  task automatic run_phase();
    int unsigned len, span, lo, sel, queries, x;
    longint cur, step_max, base;
    bit scrambled;
    logic [INDEX_W-1:0] s;
    logic signed [VALUE_W-1:0] thr;
    sel = $urandom_range(0, 99);
    if (sel < 8) len = 0;
    else if (sel < 18) len = DEPTH;
    else if (sel < 45) len = $urandom_range(1, 16);
    else if (sel < 85) len = $urandom_range(17, 200);
    else len = $urandom_range(201, DEPTH - 1);
    apply_length(LENGTH_W'(len));

    span = $urandom_range(2, 48);
    if (span > len) span = len;
    lo = len - span;
    scrambled = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 3))
      0: cur = SUM_MAX;
      1: cur = longint'($signed($urandom));
      default: cur = longint'($urandom_range(0, 1 << 20));
    endcase
    step_max = 64'd1 << $urandom_range(0, 24);
    for (int unsigned i = lo; i < len; i++) begin
      push_request(write_row(i, scrambled ? $urandom : cur[VALUE_W-1:0]));
      cur -= longint'($urandom_range(0, 32'(step_max)));
      if (cur < SUM_MIN) cur = SUM_MIN;
    end

    queries = $urandom_range(8, 28);
    repeat (queries) begin
      // Stray writes overwrite random entries with random values
      if ($urandom_range(0, 99) < 8) begin
        push_request(write_row($urandom_range(0, DEPTH - 1), $urandom));
        continue;
      end
      if (len < DEPTH && (len == 0 || $urandom_range(0, 9) == 0))
        s = INDEX_W'($urandom_range(len, DEPTH - 1));
      else if (lo == 0)
        s = INDEX_W'($urandom_range(0, len - 1));
      else
        s = INDEX_W'($urandom_range(lo + 1, len - 1));
      sel = $urandom_range(0, 99);
      if (sel < 8 || s >= len) thr = $urandom;
      else if (sel < 12) thr = SUM_MIN[VALUE_W-1:0];
      else if (sel < 16) thr = SUM_MAX[VALUE_W-1:0];
      else begin
        // Aim the threshold at the factor sum of a random end position
        x = $urandom_range(s, len - 1);
        base = (s == 0) ? 0 : longint'(prefix_sums[s-1]);
        thr = clamp_sum(longint'(prefix_sums[x]) - base
                        + longint'($urandom_range(0, 4)) - 2);
      end
      push_request(query_row(s, thr, 1'b0, LAST_NONE));
    end
  endtask

  // Take results, check them in order, and drive the stall
  always @(posedge clk) begin
    logic signed [LAST_W-1:0] want;
    if (rst_n) begin
      if (out_valid === 1'b1 && !out_stall) begin
        results_seen++;
        if (ring_wr == ring_rd) begin
          report("unexpected result", LAST_NONE, out_last_index);
        end else begin
          want = want_ring[ring_rd % RING_DEPTH];
          ring_rd++;
          if (out_last_index !== want) report("mismatch", want, out_last_index);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT && in_valid === 1'b1) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= roll_idle();
      end
    end
  end

  initial begin
    // Empty table, start at the top of the address range, then a short table
    add_row(query_row(0, 32'sh0000_0000, 1'b1, LAST_NONE));
    add_row(query_row(4095, SUM_MIN[31:0], 1'b1, LAST_NONE));
    add_row(length_row(8));
    add_row(write_row(0, 32'sh7FFF_FFFF));
    add_row(write_row(1, 32'sh0001_0000));
    add_row(write_row(2, 32'sh0000_0000));
    add_row(write_row(3, 32'shFFFF_0000));
    add_row(write_row(4, 32'shFFFE_0000));
    add_row(write_row(5, 32'shFFFD_0000));
    add_row(write_row(6, 32'shFFFC_0000));
    add_row(write_row(7, 32'sh8000_0000));
    // Lowest threshold runs to the last entry
    add_row(query_row(0, SUM_MIN[31:0], 1'b1, 13'sd7));
    add_row(query_row(0, SUM_MAX[31:0], 1'b0, LAST_NONE));
    // Nothing qualifies from a nonzero start
    add_row(query_row(1, SUM_MAX[31:0], 1'b1, LAST_NONE));
    add_row(query_row(7, 32'sh0000_0000, 1'b0, LAST_NONE));
    // Start equal to the length reads nothing
    add_row(query_row(8, SUM_MIN[31:0], 1'b1, LAST_NONE));
    add_row(query_row(4, 32'shFFFF_0000, 1'b0, LAST_NONE));
    // Factor sum below the 32-bit range
    add_row(query_row(1, SUM_MIN[31:0], 1'b0, LAST_NONE));
    // Break monotonicity
    add_row(write_row(2, 32'sh7FFF_0000));
    add_row(query_row(0, 32'sh0000_0000, 1'b0, LAST_NONE));
    add_row(write_row(4095, 32'shFFFF_FFFF));
    add_row(query_row(4095, 32'shFFFF_FFFF, 1'b1, LAST_NONE));
    // Single entry table
    add_row(length_row(1));
    add_row(query_row(0, SUM_MIN[31:0], 1'b1, 13'sd0));
    add_row(query_row(0, SUM_MAX[31:0], 1'b0, LAST_NONE));
    add_row(query_row(1, 32'sh0000_0000, 1'b1, LAST_NONE));

    // Hold reset low from the start, then release it
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < row_count; i++) begin
      if (directed_rows[i].kind == ROW_CONFIG) apply_length(directed_rows[i].length);
      else push_request(directed_rows[i]);
    end

    while (requests_sent < ITEM_TARGET) run_phase();

    // Drop valid, wait out the last results and any trailing write
    if (in_valid) in_valid <= 1'b0;
    while (ring_wr != ring_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
